// ===== hdl/mkdlp_pkg.sv =====
// Shared types and defaults for the multi-key debouncer with long-press detection.
// Used by the key lane, the event merger and the top level.
`default_nettype none
package mkdlp_pkg;

	localparam int NUM_KEYS_DEF   = 11;
	localparam int HOLD_W         = 16;
	localparam int HOLD_RESET     = 140;
	localparam int CFG_IDX_W      = 8;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_MASK    = 8'd1;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_LONG    = 2'd2,
		EV_NONE    = 2'd3
	} ev_kind_t;

	// What one key lane found on the current tick
	typedef struct packed {
		logic     hit;
		ev_kind_t kind;
		logic     stable;
	} lane_res_t;

endpackage
`default_nettype wire

// ===== hdl/multi_key_debounce_long_press_top.sv =====
// Multi-key debouncer with long-press events: top level with stream ports and config.
// Depends on mkdlp_pkg, mkdlp_lane and mkdlp_merge.
//
// Each accepted sample tick is debounced by one lane per key; the
// merger then sends one result per event in ascending key order, or one no-event
// result, each with the debounced mask and tlast on the tick's final result. The
// merger sends one result a cycle while the output is not stalled by m_tready; the
// next tick is taken in the cycle its predecessor's last result moves to the output
// register, so ticks with one event stream at one a cycle while the output is not
// stalled. The first tick after reset only primes the debounced state.
`default_nettype none
module multi_key_debounce_long_press_top #(
	parameter int NUM_KEYS = mkdlp_pkg::NUM_KEYS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// [NUM_KEYS-1:0] raw_levels, zero padded
	input  wire logic [((NUM_KEYS+7)/8)*8-1:0] s_tdata,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// [IDX_W-1:0] key_index, then pressed_mask, zero padded
	output logic [((NUM_KEYS+((NUM_KEYS>16)?$clog2(NUM_KEYS):4)+7)/8)*8-1:0] m_tdata,
	// [1:0] event_kind
	output logic [1:0]                        m_tuser,
	output logic                              m_tlast,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [mkdlp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [((NUM_KEYS>16)?NUM_KEYS:16)-1:0] cfg_data
);
	import mkdlp_pkg::*;

	localparam int IDX_W  = (NUM_KEYS > 16) ? $clog2(NUM_KEYS) : 4;
	localparam int OUT_W  = ((NUM_KEYS + IDX_W + 7) / 8) * 8;
	localparam int PAD_W  = OUT_W - NUM_KEYS - IDX_W;

	logic [HOLD_W-1:0]   long_ticks_q;
	logic [NUM_KEYS-1:0] low_act_q;
	logic                primed_q;
	logic                in_load;
	logic                can_take;
	lane_res_t           lane_res [NUM_KEYS];
	logic [IDX_W-1:0]    out_idx;
	ev_kind_t            out_kind;
	logic [NUM_KEYS-1:0] out_mask;

	assign cfg_ready = 1'b1;
	assign s_tready  = can_take;
	assign in_load   = s_tvalid && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= HOLD_W'(HOLD_RESET);
			low_act_q    <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LONG_PRESS: long_ticks_q <= cfg_data[HOLD_W-1:0];
				REG_LOW_MASK:   low_act_q    <= cfg_data[NUM_KEYS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (in_load) begin
			primed_q <= 1'b1;
		end
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		mkdlp_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (in_load),
			.primed     (primed_q),
			.level      (s_tdata[k]),
			.low_act    (low_act_q[k]),
			.threshold  (long_ticks_q),
			.res        (lane_res[k])
		);
	end

	mkdlp_merge #(
		.NUM_KEYS (NUM_KEYS),
		.IDX_W    (IDX_W)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_load),
		.lane_res  (lane_res),
		.can_take  (can_take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_idx   (out_idx),
		.out_kind  (out_kind),
		.out_mask  (out_mask),
		.out_last  (m_tlast)
	);

	if (PAD_W > 0) begin : g_pad
		assign m_tdata = {{PAD_W{1'b0}}, out_mask, out_idx};
	end else begin : g_nopad
		assign m_tdata = {out_mask, out_idx};
	end
	assign m_tuser = out_kind;

`ifndef SYNTHESIS
	// A no-event result stands alone for its tick
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_NONE) |-> m_tlast && (out_idx == '0))
		else $error("no-event result without tlast or with nonzero key");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(out_idx) < NUM_KEYS))
		else $error("key index out of range");

	// The first tick after reset never produces an event
	a_prime_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_load && !primed_q |=> !(u_merge.pend_vec_q != '0))
		else $error("priming tick produced events");
`endif

endmodule
`default_nettype wire

// ===== hdl/mkdlp_lane.sv =====
// Per-key debounce lane: two-sample agreement, hold counter and long-press flag.
// Depends on mkdlp_pkg.
`default_nettype none
module mkdlp_lane (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic                       primed,
	input  wire logic                       level,
	input  wire logic                       low_act,
	input  wire logic [mkdlp_pkg::HOLD_W-1:0] threshold,
	output mkdlp_pkg::lane_res_t            res
);
	import mkdlp_pkg::*;

	logic              prev_q;
	logic              stable_q;
	logic [HOLD_W-1:0] hold_q;
	logic              long_q;

	logic              smp;
	logic              vote;
	logic [HOLD_W-1:0] hold_inc;

	assign smp      = level ^ low_act;
	assign vote     = (smp == prev_q) ? smp : stable_q;
	assign hold_inc = (hold_q < threshold) ? hold_q + 1'b1 : hold_q;

	always_comb begin
		res.hit    = 1'b0;
		res.kind   = EV_NONE;
		res.stable = stable_q;
		if (!primed) begin
			res.stable = smp;
		end else if (vote != stable_q) begin
			res.hit    = 1'b1;
			res.kind   = vote ? EV_PRESS : EV_RELEASE;
			res.stable = vote;
		end else if (vote && !long_q && hold_inc >= threshold) begin
			res.hit  = 1'b1;
			res.kind = EV_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			stable_q <= 1'b0;
			hold_q   <= '0;
			long_q   <= 1'b0;
		end else if (load) begin
			prev_q <= smp;
			if (!primed) begin
				stable_q <= smp;
				hold_q   <= '0;
				long_q   <= 1'b0;
			end else if (vote != stable_q) begin
				stable_q <= vote;
				hold_q   <= '0;
				if (vote) begin
					long_q <= 1'b0;
				end
			end else if (vote) begin
				hold_q <= hold_inc;
				if (!long_q && hold_inc >= threshold) begin
					long_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mkdlp_merge.sv =====
// Event merger: holds one tick's lane results and sends them out lowest key first.
// Depends on mkdlp_pkg; fed by the mkdlp_lane instances in the top level.
`default_nettype none
module mkdlp_merge #(
	parameter int NUM_KEYS = mkdlp_pkg::NUM_KEYS_DEF,
	parameter int IDX_W    = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire mkdlp_pkg::lane_res_t  lane_res [NUM_KEYS],
	output logic                       can_take,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [IDX_W-1:0]           out_idx,
	output mkdlp_pkg::ev_kind_t        out_kind,
	output logic [NUM_KEYS-1:0]        out_mask,
	output logic                       out_last
);
	import mkdlp_pkg::*;

	localparam int SEL_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic                pend_valid_q;
	logic [NUM_KEYS-1:0] pend_vec_q;
	ev_kind_t            pend_kind_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] pend_mask_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	ev_kind_t            out_kind_q;
	logic [NUM_KEYS-1:0] out_mask_q;
	logic                out_last_q;

	logic [SEL_W-1:0]    sel;
	logic [NUM_KEYS-1:0] rest;
	logic                any_ev;
	logic                out_load;
	logic                pend_done;

	// Lowest pending key wins
	always_comb begin
		sel = '0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (pend_vec_q[i]) begin
				sel = SEL_W'(i);
			end
		end
	end

	assign any_ev    = |pend_vec_q;
	assign rest      = pend_vec_q & (pend_vec_q - 1'b1);
	assign out_load  = pend_valid_q && (!out_valid_q || out_ready);
	assign pend_done = out_load && (rest == '0);
	assign can_take  = !pend_valid_q || pend_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_vec_q   <= '0;
		end else if (load) begin
			pend_valid_q <= 1'b1;
			for (int i = 0; i < NUM_KEYS; i++) begin
				pend_vec_q[i] <= lane_res[i].hit;
			end
		end else if (pend_done) begin
			pend_valid_q <= 1'b0;
			pend_vec_q   <= '0;
		end else if (out_load) begin
			pend_vec_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				pend_kind_q[i] <= lane_res[i].kind;
				pend_mask_q[i] <= lane_res[i].stable;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q  <= any_ev ? IDX_W'(sel) : '0;
			out_kind_q <= any_ev ? pend_kind_q[sel] : EV_NONE;
			out_mask_q <= pend_mask_q;
			out_last_q <= (rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_idx   = out_idx_q;
	assign out_kind  = out_kind_q;
	assign out_mask  = out_mask_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire
